>>> rtl/hufd_pkg.sv
// shared types and constants for the huffman tree stream decoder
// no dependencies; imported by hufd_ctrl, hufd_dp and the top module of the block
package hufd_pkg;

  localparam int MAX_NODES     = 1024;
  localparam int STACK_DEPTH   = 256;
  localparam int BITS_PER_BYTE = 8;
  localparam int NODE_W        = $clog2(MAX_NODES);
  localparam int CNT_W         = $clog2(MAX_NODES + 1);
  localparam int STK_AW        = $clog2(STACK_DEPTH);
  localparam int SP_W          = $clog2(STACK_DEPTH + 1);
  localparam int BIDX_W        = $clog2(BITS_PER_BYTE);
  localparam int LBC_W         = $clog2(BITS_PER_BYTE + 1);
  localparam int INFO_W        = 10;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DECODE,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    HS_TYPE,
    HS_KIND,
    HS_CHAR,
    HS_SKIP
  } hs_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIT,
    S_POP,
    S_DEC1,
    S_DEC2,
    S_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic pop;
    logic dread;
    logic deval;
    logic flush;
    logic adv;
  } cmd_t;

  typedef struct packed {
    logic phase_done;
    logic go_pop;
    logic go_walk;
    logic last_bit;
    logic can_emit;
    logic pend_v;
    logic out_free;
  } stat_t;

endpackage

>>> rtl/hufd_ctrl.sv
// sequencing state machine: steps one header or decode bit at a time
// depends on hufd_pkg; drives commands into hufd_dp
module hufd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  hufd_pkg::stat_t stat,
  output hufd_pkg::cmd_t  cmd
);
  import hufd_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_BIT;
        end
      end
      S_BIT: begin
        if (stat.phase_done) begin
          state_nxt = S_FLUSH;
        end else if (stat.can_emit) begin
          cmd.step = 1'b1;
          if (stat.go_pop) begin
            state_nxt = S_POP;
          end else if (stat.go_walk) begin
            state_nxt = S_DEC1;
          end else if (stat.last_bit) begin
            state_nxt = S_FLUSH;
          end else begin
            cmd.adv = 1'b1;
          end
        end
      end
      S_POP: begin
        cmd.pop = 1'b1;
        if (stat.last_bit) begin
          state_nxt = S_FLUSH;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = S_BIT;
        end
      end
      S_DEC1: begin
        cmd.dread = 1'b1;
        state_nxt = S_DEC2;
      end
      S_DEC2: begin
        if (stat.can_emit) begin
          cmd.deval = 1'b1;
          if (stat.last_bit) begin
            state_nxt = S_FLUSH;
          end else begin
            cmd.adv   = 1'b1;
            state_nxt = S_BIT;
          end
        end
      end
      S_FLUSH: begin
        if (!stat.pend_v) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/hufd_dp.sv
// datapath: node table, parent stack, header and walk registers, result registers
// depends on hufd_pkg; commanded by hufd_ctrl
module hufd_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hufd_pkg::cmd_t       cmd,
  output hufd_pkg::stat_t      stat,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_first_of_stream,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_symbol,
  output logic                 out_end_of_stream,
  output logic                 out_last
);
  import hufd_pkg::*;

  // node table and parent stack
  logic [NODE_W-1:0] left_mem  [MAX_NODES];
  logic [NODE_W-1:0] right_mem [MAX_NODES];
  logic [INFO_W-1:0] info_mem  [MAX_NODES];
  logic [NODE_W-1:0] stk_mem   [STACK_DEPTH];

  logic [NODE_W-1:0] left_rd_r, right_rd_r, stk_rd_r;
  logic [INFO_W-1:0] info_rd_r;

  logic [7:0]        byte_r, byte_nxt;
  logic [BIDX_W-1:0] bcnt_r, bcnt_nxt;
  phase_t            phase_r, phase_nxt;
  hs_t               hs_r, hs_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [LBC_W-1:0]  lbc_r, lbc_nxt;
  logic [CNT_W-1:0]  ncount_r, ncount_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic [NODE_W-1:0] child_r, child_nxt;
  logic              prev_leaf_r, prev_leaf_nxt;
  logic              root_leaf_r, root_leaf_nxt;
  logic              root_eof_r, root_eof_nxt;
  logic [7:0]        root_char_r, root_char_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [7:0]        pend_sym_r, pend_sym_nxt;
  logic              pend_eos_r, pend_eos_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_sym_r, out_sym_nxt;
  logic              out_eos_r, out_eos_nxt;
  logic              out_last_r, out_last_nxt;

  // memory port controls
  logic              left_we, right_we, info_we, stk_we;
  logic [NODE_W-1:0] left_waddr, left_wdata, right_waddr, right_wdata, info_waddr;
  logic [INFO_W-1:0] info_wdata;
  logic [STK_AW-1:0] stk_waddr, stk_raddr;
  logic [NODE_W-1:0] stk_wdata;
  logic              stk_re, lr_re, info_re;
  logic [NODE_W-1:0] info_raddr;

  logic              bit_w;
  logic [NODE_W-1:0] n_idx;
  logic              tbl_full;
  logic              out_free;

  assign bit_w    = byte_r[bcnt_r];
  assign n_idx    = ncount_r[NODE_W-1:0];
  assign tbl_full = (ncount_r >= CNT_W'(MAX_NODES));
  assign out_free = !out_valid_r || !out_stall;

  assign stat.phase_done = (phase_r == PH_DONE);
  assign stat.go_pop     = (phase_r == PH_HEADER) && (hs_r == HS_TYPE) && !tbl_full &&
                           (ncount_r != '0) && prev_leaf_r && (sp_r != '0);
  assign stat.go_walk    = (phase_r == PH_DECODE) && !((cur_r == '0) && root_leaf_r);
  assign stat.last_bit   = (bcnt_r == '0);
  assign stat.can_emit   = !pend_v_r || out_free;
  assign stat.pend_v     = pend_v_r;
  assign stat.out_free   = out_free;

  always_comb begin
    logic              do_create;
    logic [SP_W-1:0]   sp_eff;
    logic              leaf_fin;
    logic              leaf_eof;
    logic [7:0]        leaf_char;
    logic              emit;
    logic [7:0]        e_sym;
    logic              e_eos;
    logic [NODE_W-1:0] child;

    do_create = 1'b0;
    sp_eff    = sp_r;
    leaf_fin  = 1'b0;
    leaf_eof  = 1'b0;
    leaf_char = '0;
    emit      = 1'b0;
    e_sym     = '0;
    e_eos     = 1'b0;
    child     = bit_w ? right_rd_r : left_rd_r;

    byte_nxt      = byte_r;
    bcnt_nxt      = bcnt_r;
    phase_nxt     = phase_r;
    hs_nxt        = hs_r;
    shift_nxt     = shift_r;
    lbc_nxt       = lbc_r;
    ncount_nxt    = ncount_r;
    sp_nxt        = sp_r;
    cur_nxt       = cur_r;
    child_nxt     = child_r;
    prev_leaf_nxt = prev_leaf_r;
    root_leaf_nxt = root_leaf_r;
    root_eof_nxt  = root_eof_r;
    root_char_nxt = root_char_r;
    pend_v_nxt    = pend_v_r;
    pend_sym_nxt  = pend_sym_r;
    pend_eos_nxt  = pend_eos_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_sym_nxt   = out_sym_r;
    out_eos_nxt   = out_eos_r;
    out_last_nxt  = out_last_r;

    left_we     = 1'b0;
    left_waddr  = n_idx - NODE_W'(1);
    left_wdata  = n_idx;
    right_we    = 1'b0;
    right_waddr = stk_rd_r;
    right_wdata = n_idx;
    info_we     = 1'b0;
    info_waddr  = n_idx;
    info_wdata  = '0;
    stk_we      = 1'b0;
    stk_waddr   = sp_r[STK_AW-1:0];
    stk_wdata   = n_idx;
    stk_re      = 1'b0;
    stk_raddr   = STK_AW'(sp_r - SP_W'(1));
    lr_re       = 1'b0;
    info_re     = 1'b0;
    info_raddr  = child;

    if (cmd.load) begin
      byte_nxt = in_data_byte;
      bcnt_nxt = BIDX_W'(BITS_PER_BYTE - 1);
      if (in_first_of_stream) begin
        phase_nxt  = PH_HEADER;
        hs_nxt     = HS_TYPE;
        shift_nxt  = '0;
        lbc_nxt    = '0;
        ncount_nxt = '0;
        sp_nxt     = '0;
        cur_nxt    = '0;
      end
    end

    if (cmd.step && phase_r == PH_HEADER) begin
      case (hs_r)
        HS_TYPE: begin
          if (tbl_full) begin
            phase_nxt = PH_DONE;
          end else if (ncount_r != '0 && prev_leaf_r) begin
            if (sp_r == '0) begin
              phase_nxt = PH_DONE;
            end else begin
              // fetch the parent awaiting a right child
              stk_re = 1'b1;
              sp_nxt = sp_r - SP_W'(1);
            end
          end else begin
            left_we   = (ncount_r != '0);
            do_create = 1'b1;
          end
        end
        HS_KIND: begin
          hs_nxt    = bit_w ? HS_SKIP : HS_CHAR;
          shift_nxt = '0;
          lbc_nxt   = '0;
        end
        HS_CHAR: begin
          shift_nxt = {shift_r[6:0], bit_w};
          lbc_nxt   = lbc_r + LBC_W'(1);
          if (lbc_r + LBC_W'(1) >= LBC_W'(BITS_PER_BYTE)) begin
            leaf_fin  = 1'b1;
            leaf_char = {shift_r[6:0], bit_w};
          end
        end
        HS_SKIP: begin
          lbc_nxt = lbc_r + LBC_W'(1);
          if (lbc_r + LBC_W'(1) >= LBC_W'(BITS_PER_BYTE)) begin
            leaf_fin = 1'b1;
            leaf_eof = 1'b1;
          end
        end
        default: begin
          hs_nxt = HS_TYPE;
        end
      endcase
    end

    if (cmd.pop) begin
      right_we  = 1'b1;
      do_create = 1'b1;
      sp_eff    = sp_r;
    end

    if (do_create) begin
      if (bit_w) begin
        info_we       = 1'b1;
        info_wdata    = {1'b1, 1'b0, 8'h00};
        hs_nxt        = HS_KIND;
        prev_leaf_nxt = 1'b1;
        ncount_nxt    = ncount_r + CNT_W'(1);
      end else if (sp_eff >= SP_W'(STACK_DEPTH)) begin
        phase_nxt = PH_DONE;
      end else begin
        info_we       = 1'b1;
        info_wdata    = '0;
        stk_we        = 1'b1;
        stk_waddr     = sp_eff[STK_AW-1:0];
        sp_nxt        = sp_eff + SP_W'(1);
        prev_leaf_nxt = 1'b0;
        ncount_nxt    = ncount_r + CNT_W'(1);
      end
    end

    if (leaf_fin) begin
      info_we    = 1'b1;
      info_waddr = n_idx - NODE_W'(1);
      info_wdata = {1'b1, leaf_eof, leaf_char};
      hs_nxt     = HS_TYPE;
      shift_nxt  = '0;
      lbc_nxt    = '0;
      if (sp_r == '0) begin
        // header complete
        phase_nxt     = PH_DECODE;
        cur_nxt       = '0;
        root_leaf_nxt = (ncount_r == CNT_W'(1));
        root_eof_nxt  = leaf_eof;
        root_char_nxt = leaf_char;
        if (leaf_eof && ncount_r == CNT_W'(1)) begin
          emit      = 1'b1;
          e_eos     = 1'b1;
          phase_nxt = PH_DONE;
        end
      end
    end

    if (cmd.step && phase_r == PH_DECODE) begin
      if (cur_r == '0 && root_leaf_r) begin
        emit = 1'b1;
        if (root_eof_r) begin
          e_eos     = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          e_sym = root_char_r;
        end
      end else begin
        lr_re = 1'b1;
      end
    end

    if (cmd.dread) begin
      info_re   = 1'b1;
      child_nxt = child;
    end

    if (cmd.deval) begin
      if (info_rd_r[9]) begin
        cur_nxt = '0;
        emit    = 1'b1;
        if (info_rd_r[8]) begin
          e_eos     = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          e_sym = info_rd_r[7:0];
        end
      end else begin
        cur_nxt = child_r;
      end
    end

    // a result waits in pend until the next one or the end of the byte sets last
    if (emit) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_sym_nxt   = pend_sym_r;
        out_eos_nxt   = pend_eos_r;
        out_last_nxt  = 1'b0;
      end
      pend_v_nxt   = 1'b1;
      pend_sym_nxt = e_sym;
      pend_eos_nxt = e_eos;
    end

    if (cmd.flush) begin
      out_valid_nxt = 1'b1;
      out_sym_nxt   = pend_sym_r;
      out_eos_nxt   = pend_eos_r;
      out_last_nxt  = 1'b1;
      pend_v_nxt    = 1'b0;
    end

    if (cmd.adv) begin
      bcnt_nxt = bcnt_r - BIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (left_we) begin
      left_mem[left_waddr] <= left_wdata;
    end
    if (lr_re) begin
      left_rd_r <= left_mem[cur_r];
    end
  end

  always_ff @(posedge clk) begin
    if (right_we) begin
      right_mem[right_waddr] <= right_wdata;
    end
    if (lr_re) begin
      right_rd_r <= right_mem[cur_r];
    end
  end

  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[info_waddr] <= info_wdata;
    end
    if (info_re) begin
      info_rd_r <= info_mem[info_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rd_r <= stk_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      hs_r        <= HS_TYPE;
      shift_r     <= '0;
      lbc_r       <= '0;
      ncount_r    <= '0;
      sp_r        <= '0;
      cur_r       <= '0;
      prev_leaf_r <= 1'b0;
      root_leaf_r <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      bcnt_r      <= '0;
    end else begin
      phase_r     <= phase_nxt;
      hs_r        <= hs_nxt;
      shift_r     <= shift_nxt;
      lbc_r       <= lbc_nxt;
      ncount_r    <= ncount_nxt;
      sp_r        <= sp_nxt;
      cur_r       <= cur_nxt;
      prev_leaf_r <= prev_leaf_nxt;
      root_leaf_r <= root_leaf_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      bcnt_r      <= bcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    child_r     <= child_nxt;
    root_eof_r  <= root_eof_nxt;
    root_char_r <= root_char_nxt;
    pend_sym_r  <= pend_sym_nxt;
    pend_eos_r  <= pend_eos_nxt;
    out_sym_r   <= out_sym_nxt;
    out_eos_r   <= out_eos_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_symbol        = out_sym_r;
  assign out_end_of_stream = out_eos_r;
  assign out_last          = out_last_r;

endmodule

>>> rtl/huffman_tree_stream_decoder_top.sv
// Huffman stream decoder with a preorder tree header. One byte is taken per request
// and its 8 bits are handled one after another, MSB first: a header bit goes through
// the bit step, followed by a pop step when a leaf is followed by a node that pops
// a parent off the stack; a decode bit goes through child index read, leaf info read
// and evaluate because of the registered node table reads, or the bit step alone when
// the root is a leaf. A new byte is taken only after the previous one is finished; once
// the stream is done, bytes are taken and ignored. Results backpressured by out_stall
// hold the block longer.
// The node table and parent stack are not cleared; first_of_stream starts a new tree.
// Depends on hufd_pkg, hufd_ctrl and hufd_dp.
module huffman_tree_stream_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_first_of_stream,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_symbol,
  output logic       out_end_of_stream,
  output logic       out_last
);
  import hufd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  hufd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  hufd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_data_byte       (in_data_byte),
    .in_first_of_stream (in_first_of_stream),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_symbol         (out_symbol),
    .out_end_of_stream  (out_end_of_stream),
    .out_last           (out_last)
  );

endmodule

>>> rtl/hufd_checker.sv
// port-level checks for the huffman stream decoder
// depends on huffman_tree_stream_decoder_top, to which it is bound
module hufd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_symbol,
  input logic       out_end_of_stream,
  input logic       out_last
);

  // end result carries no symbol
  a_eos_sym: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_stream |-> out_symbol == 8'h00)
    else $error("end result with nonzero symbol");

  // nothing follows the end marker within a byte
  a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_stream |-> out_last)
    else $error("end result not marked last");

  // the input is stalled in the cycle after a byte is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous byte in flight");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_symbol) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind huffman_tree_stream_decoder_top hufd_checker u_hufd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_symbol        (out_symbol),
  .out_end_of_stream (out_end_of_stream),
  .out_last          (out_last)
);

>>> sim/huffman_tree_stream_decoder_top_tb.sv
// testbench for huffman_tree_stream_decoder_top: directed header and decode cases,
// then random well-formed and broken streams checked against an in-bench tree decoder
// depends on hufd_pkg and the rtl of the block
`timescale 1ns / 100ps

module huffman_tree_stream_decoder_top_tb;
  import hufd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 60;
  localparam logic [9:0] LEAF_BIT = 10'h200;

  typedef struct packed {
    logic [7:0] sym;
    logic       eos;
    logic       last;
  } sym_res_t;

  typedef struct {
    logic [7:0] data;
    bit         first;
    int         n;     // -1: decoder model decides
    logic [7:0] sym;
    logic       eos;
  } row_t;

  logic       clk = 0;
  logic       rst_n = 0;
  logic       in_valid = 0;
  logic       in_stall;
  logic [7:0] in_data_byte = 0;
  logic       in_first_of_stream = 0;
  logic       out_valid;
  logic       out_stall = 0;
  logic [7:0] out_symbol;
  logic       out_end_of_stream;
  logic       out_last;

  huffman_tree_stream_decoder_top u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_byte, .in_first_of_stream,
    .out_valid, .out_stall, .out_symbol, .out_end_of_stream, .out_last
  );

  always #10 clk = ~clk;

  // decoder model state
  phase_t     dm_phase;
  hs_t        dm_hs;
  logic [7:0] dm_shift;
  int         dm_bits;
  logic [9:0] dm_left [MAX_NODES];
  logic [9:0] dm_right [MAX_NODES];
  logic [9:0] dm_info [MAX_NODES];
  int         dm_count;
  logic [9:0] dm_stack [STACK_DEPTH];
  int         dm_sp;
  int         dm_cur;

  sym_res_t   decoded_q[$];
  int         n_err = 0;
  int         tx_idle = 0;
  int         rx_idle = 0;
  int         bytes_sent = 0;
  int         quiet_cycles = 0;
  bit         typed_on = 0;
  int         typed_n;
  logic [7:0] typed_sym;
  logic       typed_eos;

  // random stream builder
  bit          bits_q[$];
  logic [7:0]  sym_tab[$];
  logic [15:0] code_tab[$];
  int          len_tab[$];
  logic [15:0] end_code;
  int          end_len;
  int          leaf_seen;
  int          end_pick;

  function automatic void dm_restart();
    dm_phase = PH_HEADER;
    dm_hs    = HS_TYPE;
    dm_shift = 0;
    dm_bits  = 0;
    dm_count = 0;
    dm_sp    = 0;
    dm_cur   = 0;
  endfunction

  function automatic bit dm_new_node(bit leaf);
    if (dm_count >= MAX_NODES) return 0;
    if (dm_count > 0) begin
      if (dm_info[dm_count-1][9]) begin
        if (dm_sp == 0) return 0;
        dm_sp--;
        dm_right[dm_stack[dm_sp]] = 10'(dm_count);
      end else begin
        dm_left[dm_count-1] = 10'(dm_count);
      end
    end
    if (leaf) begin
      dm_info[dm_count] = LEAF_BIT;
    end else begin
      if (dm_sp >= STACK_DEPTH) return 0;
      dm_info[dm_count] = 0;
      dm_stack[dm_sp] = 10'(dm_count);
      dm_sp++;
    end
    dm_count++;
    return 1;
  endfunction

  function automatic bit dm_leaf_done(logic [9:0] leaf_info);
    dm_info[dm_count-1] = leaf_info;
    dm_hs    = HS_TYPE;
    dm_shift = 0;
    dm_bits  = 0;
    if (dm_sp == 0) begin
      dm_phase = PH_DECODE;
      dm_cur   = 0;
      return 1;
    end
    return 0;
  endfunction

  task automatic decode_byte(input logic [7:0] data, input bit first, ref sym_res_t res[$]);
    bit         b;
    bit         complete;
    int         node;
    logic [9:0] li;
    if (first) dm_restart();
    for (int k = 7; k >= 0; k--) begin
      b = data[k];
      if (dm_phase == PH_HEADER) begin
        complete = 0;
        case (dm_hs)
          HS_TYPE: begin
            if (!dm_new_node(b)) begin
              dm_phase = PH_DONE;
              break;
            end
            if (b) dm_hs = HS_KIND;
          end
          HS_KIND: begin
            dm_hs    = b ? HS_SKIP : HS_CHAR;
            dm_shift = 0;
            dm_bits  = 0;
          end
          HS_CHAR: begin
            dm_shift = {dm_shift[6:0], b};
            dm_bits++;
            if (dm_bits >= 8) complete = dm_leaf_done(LEAF_BIT | dm_shift);
          end
          default: begin
            dm_bits++;
            if (dm_bits >= 8) complete = dm_leaf_done(10'h300);
          end
        endcase
        if (complete && dm_info[0][8]) begin
          res.push_back('{sym: 0, eos: 1, last: 0});
          dm_phase = PH_DONE;
          break;
        end
      end else if (dm_phase == PH_DECODE) begin
        node = dm_cur;
        if (!dm_info[node][9]) node = b ? dm_right[node] : dm_left[node];
        li = dm_info[node];
        if (li[9]) begin
          dm_cur = 0;
          if (li[8]) begin
            res.push_back('{sym: 0, eos: 1, last: 0});
            dm_phase = PH_DONE;
            break;
          end
          res.push_back('{sym: li[7:0], eos: 0, last: 0});
        end else begin
          dm_cur = node;
        end
      end else begin
        break;
      end
    end
    if (res.size() > 0) res[res.size()-1].last = 1;
  endtask

  task automatic mismatch(input string what);
    if (n_err < 10) $display("%0t mismatch: %s", $realtime, what);
    n_err++;
  endtask

  // accepted request -> expected symbols
  always @(posedge clk) begin
    sym_res_t got[$];
    got.delete();
    if (rst_n && in_valid && !in_stall) begin
      decode_byte(in_data_byte, in_first_of_stream, got);
      if (typed_on) begin
        for (int i = 0; i < typed_n; i++)
          decoded_q.push_back('{sym: typed_sym, eos: typed_eos, last: i == typed_n - 1});
      end else begin
        foreach (got[i]) decoded_q.push_back(got[i]);
      end
    end
  end

  always @(posedge clk) begin
    sym_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        mismatch($sformatf("unexpected result sym=%02h eos=%0b last=%0b",
                           out_symbol, out_end_of_stream, out_last));
      end else begin
        want = decoded_q.pop_front();
        if (out_symbol !== want.sym || out_end_of_stream !== want.eos ||
            out_last !== want.last)
          mismatch($sformatf("exp sym=%02h eos=%0b last=%0b got sym=%02h eos=%0b last=%0b",
                             want.sym, want.eos, want.last,
                             out_symbol, out_end_of_stream, out_last));
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < rx_idle);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("huffman_tree_stream_decoder_top_tb NOT OK");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] data, input bit first);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid           <= 1;
    in_data_byte       <= data;
    in_first_of_stream <= first;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    wait (decoded_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void grow(int leaves, logic [15:0] code, int len);
    int         split;
    logic [7:0] ch;
    if (leaves == 1) begin
      ch = 8'($urandom_range(255));
      bits_q.push_back(1);
      if (leaf_seen == end_pick) begin
        bits_q.push_back(1);
        end_code = code;
        end_len  = len;
      end else begin
        bits_q.push_back(0);
        sym_tab.push_back(ch);
        code_tab.push_back(code);
        len_tab.push_back(len);
      end
      for (int i = 7; i >= 0; i--) bits_q.push_back(ch[i]);
      leaf_seen++;
    end else begin
      bits_q.push_back(0);
      split = $urandom_range(1, leaves - 1);
      grow(split, code << 1, len + 1);
      grow(leaves - split, (code << 1) | 1, len + 1);
    end
  endfunction

  task automatic send_bits();
    logic [7:0] b;
    while (bits_q.size() % 8 != 0) bits_q.push_back($urandom_range(1));
    for (int i = 0; i < bits_q.size(); i += 8) begin
      for (int j = 0; j < 8; j++) b[7-j] = bits_q[i+j];
      send_byte(b, i == 0);
    end
  endtask

  task automatic send_stream();
    int leaves;
    int nsym;
    int pick;
    int keep;
    bits_q.delete();
    sym_tab.delete();
    code_tab.delete();
    len_tab.delete();
    if ($urandom_range(7) == 0) begin
      // noise: random header bits
      repeat ($urandom_range(1, 5)) bits_q.push_back($urandom_range(1));
      repeat ($urandom_range(8, 40)) bits_q.push_back($urandom_range(1));
      send_bits();
      return;
    end
    leaves    = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 12);
    leaf_seen = 0;
    end_pick  = ($urandom_range(4) == 0) ? leaves : $urandom_range(leaves - 1);
    grow(leaves, 0, 0);
    nsym = $urandom_range(1, 30);
    for (int i = 0; i < nsym && sym_tab.size() > 0; i++) begin
      pick = $urandom_range(sym_tab.size() - 1);
      if (len_tab[pick] == 0) bits_q.push_back($urandom_range(1));
      for (int j = len_tab[pick] - 1; j >= 0; j--) bits_q.push_back(code_tab[pick][j]);
    end
    if (end_pick < leaves && $urandom_range(3) != 0)
      for (int j = end_len - 1; j >= 0; j--) bits_q.push_back(end_code[j]);
    if ($urandom_range(9) == 0) begin
      // broken stream: cut short, the next stream restarts it
      keep = $urandom_range(1, bits_q.size());
      while (bits_q.size() > keep) void'(bits_q.pop_back());
    end
    send_bits();
  endtask

  row_t rows[] = '{
    '{8'hC0, 1, 0, 8'h00, 0},   // root is the end leaf, skip bits straddle bytes
    '{8'h3F, 0, 1, 8'h00, 1},
    '{8'h55, 0, 0, 8'h00, 0},   // done: ignored
    '{8'hBF, 1, 0, 8'h00, 0},   // root is a character leaf 0xff
    '{8'hFF, 0, 6, 8'hFF, 0},
    '{8'h00, 0, 8, 8'hFF, 0},
    '{8'hFF, 0, 8, 8'hFF, 0},
    '{8'h80, 1, 0, 8'h00, 0},   // root is a character leaf 0x00
    '{8'h00, 0, 6, 8'h00, 0},
    '{8'h48, 1, -1, 8'h00, 0},  // root with 'A' left and end right
    '{8'h38, 0, -1, 8'h00, 0},
    '{8'h00, 0, -1, 8'h00, 0},
    '{8'h00, 0, -1, 8'h00, 0},
    '{8'h01, 0, -1, 8'h00, 0},
    '{8'hAA, 0, 0, 8'h00, 0},
    '{8'hFF, 1, 0, 8'h00, 0},
    '{8'hFF, 0, 1, 8'h00, 1}
  };

  initial begin
    dm_restart();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    foreach (rows[i]) begin
      // change the expected row away from the accepting edge
      @(negedge clk);
      typed_on  = rows[i].n >= 0;
      typed_n   = rows[i].n;
      typed_sym = rows[i].sym;
      typed_eos = rows[i].eos;
      send_byte(rows[i].data, rows[i].first);
    end
    @(negedge clk);
    typed_on = 0;
    drain();

    // parent stack overflow: a long run of internal nodes
    for (int i = 0; i < 34; i++) send_byte(8'h00, i == 0);
    drain();

    for (int p = 0; p < 3; p++) begin
      tx_idle = (p == 0) ? 6 : (p == 1) ? 53 : 0;
      rx_idle = (p == 0) ? 53 : (p == 1) ? 6 : 0;
      bytes_sent = 0;
      while (bytes_sent < 130) send_stream();
      drain();
    end

    if (n_err == 0) $display("huffman_tree_stream_decoder_top_tb OK");
    else $display("huffman_tree_stream_decoder_top_tb NOT OK");
    $finish;
  end

endmodule
